FILE: sv/mmf_pkg.sv
// Package of the MTU message fragmenter: codes, constants, item and result types.
`timescale 1ns / 1ps

package mmf_pkg;

  localparam int FRAME_BUFFER_BYTES = 244;
  localparam int MAX_RESULTS        = 5;
  localparam int CNT_W              = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] MTU_RESET    = 16'd23;
  localparam logic [15:0] MTU_OVERHEAD = 16'd3;
  localparam logic [15:0] MIN_ROOM     = 16'd5;
  localparam logic [7:0]  FIRST_HDR    = 8'd5;
  localparam logic [7:0]  NEXT_HDR     = 8'd3;
  localparam logic [7:0]  MSG_TYPE     = 8'h02;
  localparam logic [7:0]  FLAG_FIRST   = 8'h01;
  localparam logic [7:0]  FLAG_LAST    = 8'h02;

  typedef enum logic [2:0] {
    KIND_START  = 3'd0,
    KIND_BYTE   = 3'd1,
    KIND_CONN   = 3'd2,
    KIND_DISC   = 3'd3,
    KIND_NOTIFY = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_FRAME     = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_MTU_SMALL = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] message_length;
    logic [7:0]  payload_byte;
    logic        connect_failed;
    logic        notify_enable;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       message_end;
    status_e    status;
  } res_t;

  typedef struct packed {
    res_t [MAX_RESULTS-1:0] ent;
    logic [CNT_W-1:0]       count;
  } burst_t;

  function automatic res_t mk_res(logic [7:0] b, logic fend, logic mend, status_e st);
    res_t r;
    r.frame_byte  = b;
    r.frame_end   = fend;
    r.message_end = mend;
    r.status      = st;
    return r;
  endfunction

endpackage

FILE: sv/mmf_if.sv
// Channel interfaces of the fragmenter: input items, result items, MTU writes.
`timescale 1ns / 1ps

interface mmf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] message_length;
  logic [7:0]  payload_byte;
  logic        connect_failed;
  logic        notify_enable;

  modport source (output valid, kind, message_length, payload_byte, connect_failed,
                  notify_enable, input ready);
  modport sink   (input valid, kind, message_length, payload_byte, connect_failed,
                  notify_enable, output ready);
endinterface

interface mmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       message_end;
  logic [1:0] status;
  logic       run_last;

  modport source (output valid, frame_byte, frame_end, message_end, status, run_last,
                  input ready);
  modport sink   (input valid, frame_byte, frame_end, message_end, status, run_last,
                  output ready);
endinterface

interface mmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: sv/mtu_message_fragmenter.sv
// Top level of the MTU message fragmenter.
//
//   channel  modport  direction  carries
//   in_i     sink     in         kind, message_length, payload_byte, connect_failed,
//                                notify_enable
//   out_o    source   out        frame_byte, frame_end, message_end, status, run_last
//   cfg_i    sink     in         data: link_mtu
//
// A request is decoded in the cycle it is accepted; its results (0 to 5) load a
// five-entry output shift register and leave one per cycle while out_o is ready.
// A request giving N results holds in_i.ready low until its last result is being
// taken; a request giving zero results lets the next one follow in the next cycle.
// A stall on out_o holds the current result and keeps in_i.ready low.
// rst_ni clears all link and message state and sets link_mtu to 23; cfg_i is
// always ready.
`timescale 1ns / 1ps

module mtu_message_fragmenter #(
  parameter int FRAME_BUFFER_BYTES = mmf_pkg::FRAME_BUFFER_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mmf_in_if.sink    in_i,
  mmf_out_if.source out_o,
  mmf_cfg_if.sink   cfg_i
);

  mmf_pkg::item_t  item;
  mmf_pkg::burst_t burst;
  mmf_pkg::res_t   res;
  logic            can_load;
  logic            fire;

  assign item.kind           = in_i.kind;
  assign item.message_length = in_i.message_length;
  assign item.payload_byte   = in_i.payload_byte;
  assign item.connect_failed = in_i.connect_failed;
  assign item.notify_enable  = in_i.notify_enable;

  assign in_i.ready  = can_load;
  assign fire        = in_i.valid && can_load;
  assign cfg_i.ready = 1'b1;

  mmf_core #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .burst_o    (burst)
  );

  mmf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .burst_i     (burst),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_res_o   (res),
    .out_last_o  (out_o.run_last),
    .can_load_o  (can_load)
  );

  assign out_o.frame_byte  = res.frame_byte;
  assign out_o.frame_end   = res.frame_end;
  assign out_o.message_end = res.message_end;
  assign out_o.status      = res.status;

endmodule

FILE: sv/mmf_core.sv
// Link state, message state and the result burst built for each accepted request.
`timescale 1ns / 1ps

module mmf_core #(
  parameter int FRAME_BUFFER_BYTES = mmf_pkg::FRAME_BUFFER_BYTES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  mmf_pkg::item_t  item_i,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_data_i,
  output mmf_pkg::burst_t burst_o
);

  logic [15:0] mtu_q;
  logic        conn_q, conn_d;
  logic        notify_q, notify_d;
  logic [7:0]  seq_cnt_q, seq_cnt_d;
  logic        active_q, active_d;
  logic [15:0] remain_q, remain_d;
  logic [7:0]  cap_q, cap_d;
  logic [7:0]  room_left_q, room_left_d;
  logic [7:0]  cur_seq_q, cur_seq_d;

  logic [15:0] room;
  logic [7:0]  cap_new;
  logic [7:0]  fit_first;
  logic [7:0]  fit_next;
  logic [15:0] remain_dec;
  logic [7:0]  room_dec;
  logic [7:0]  flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q       <= mmf_pkg::MTU_RESET;
      conn_q      <= 1'b0;
      notify_q    <= 1'b0;
      seq_cnt_q   <= '0;
      active_q    <= 1'b0;
      remain_q    <= '0;
      cap_q       <= '0;
      room_left_q <= '0;
      cur_seq_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        mtu_q <= cfg_data_i;
      end
      if (fire_i) begin
        conn_q      <= conn_d;
        notify_q    <= notify_d;
        seq_cnt_q   <= seq_cnt_d;
        active_q    <= active_d;
        remain_q    <= remain_d;
        cap_q       <= cap_d;
        room_left_q <= room_left_d;
        cur_seq_q   <= cur_seq_d;
      end
    end
  end

  assign room       = (mtu_q > mmf_pkg::MTU_OVERHEAD) ? mtu_q - mmf_pkg::MTU_OVERHEAD : '0;
  assign cap_new    = (room > 16'(FRAME_BUFFER_BYTES)) ? 8'(FRAME_BUFFER_BYTES) : room[7:0];
  assign fit_first  = cap_new - mmf_pkg::FIRST_HDR;
  assign fit_next   = cap_q - mmf_pkg::NEXT_HDR;
  assign remain_dec = remain_q - 16'd1;
  assign room_dec   = (room_left_q != '0) ? room_left_q - 8'd1 : '0;

  always_comb begin
    conn_d      = conn_q;
    notify_d    = notify_q;
    seq_cnt_d   = seq_cnt_q;
    active_d    = active_q;
    remain_d    = remain_q;
    cap_d       = cap_q;
    room_left_d = room_left_q;
    cur_seq_d   = cur_seq_q;
    flags       = '0;
    burst_o     = '0;

    unique case (mmf_pkg::kind_e'(item_i.kind))
      mmf_pkg::KIND_START: begin
        active_d = 1'b0;
        if (!(conn_q && notify_q)) begin
          burst_o.ent[0] = mmf_pkg::mk_res('0, 1'b0, 1'b0, mmf_pkg::ST_NOT_READY);
          burst_o.count  = mmf_pkg::CNT_W'(1);
        end else begin
          cur_seq_d = seq_cnt_q;
          seq_cnt_d = seq_cnt_q + 8'd1;
          if (room <= mmf_pkg::MIN_ROOM) begin
            burst_o.ent[0] = mmf_pkg::mk_res('0, 1'b0, 1'b0, mmf_pkg::ST_MTU_SMALL);
            burst_o.count  = mmf_pkg::CNT_W'(1);
          end else if (item_i.message_length != '0) begin
            cap_d    = cap_new;
            remain_d = item_i.message_length;
            active_d = 1'b1;
            // whole message fits the first frame: mark it last
            if (item_i.message_length <= {8'd0, fit_first}) begin
              room_left_d = item_i.message_length[7:0];
              flags       = mmf_pkg::FLAG_FIRST | mmf_pkg::FLAG_LAST;
            end else begin
              room_left_d = fit_first;
              flags       = mmf_pkg::FLAG_FIRST;
            end
            burst_o.ent[0] = mmf_pkg::mk_res(mmf_pkg::MSG_TYPE, 1'b0, 1'b0,
                                             mmf_pkg::ST_FRAME);
            burst_o.ent[1] = mmf_pkg::mk_res(flags, 1'b0, 1'b0, mmf_pkg::ST_FRAME);
            burst_o.ent[2] = mmf_pkg::mk_res(seq_cnt_q, 1'b0, 1'b0, mmf_pkg::ST_FRAME);
            burst_o.ent[3] = mmf_pkg::mk_res(item_i.message_length[7:0], 1'b0, 1'b0,
                                             mmf_pkg::ST_FRAME);
            burst_o.ent[4] = mmf_pkg::mk_res(item_i.message_length[15:8], 1'b0, 1'b0,
                                             mmf_pkg::ST_FRAME);
            burst_o.count  = mmf_pkg::CNT_W'(5);
          end
        end
      end
      mmf_pkg::KIND_BYTE: begin
        if (active_q) begin
          remain_d    = remain_dec;
          room_left_d = room_dec;
          if (remain_dec == '0) begin
            active_d       = 1'b0;
            room_left_d    = '0;
            burst_o.ent[0] = mmf_pkg::mk_res(item_i.payload_byte, 1'b1, 1'b1,
                                             mmf_pkg::ST_FRAME);
            burst_o.count  = mmf_pkg::CNT_W'(1);
          end else if (room_dec == '0) begin
            // frame full: close it and open the next one right away
            if (remain_dec <= {8'd0, fit_next}) begin
              room_left_d = remain_dec[7:0];
              flags       = mmf_pkg::FLAG_LAST;
            end else begin
              room_left_d = fit_next;
            end
            burst_o.ent[0] = mmf_pkg::mk_res(item_i.payload_byte, 1'b1, 1'b0,
                                             mmf_pkg::ST_FRAME);
            burst_o.ent[1] = mmf_pkg::mk_res(mmf_pkg::MSG_TYPE, 1'b0, 1'b0,
                                             mmf_pkg::ST_FRAME);
            burst_o.ent[2] = mmf_pkg::mk_res(flags, 1'b0, 1'b0, mmf_pkg::ST_FRAME);
            burst_o.ent[3] = mmf_pkg::mk_res(cur_seq_q, 1'b0, 1'b0, mmf_pkg::ST_FRAME);
            burst_o.count  = mmf_pkg::CNT_W'(4);
          end else begin
            burst_o.ent[0] = mmf_pkg::mk_res(item_i.payload_byte, 1'b0, 1'b0,
                                             mmf_pkg::ST_FRAME);
            burst_o.count  = mmf_pkg::CNT_W'(1);
          end
        end
      end
      mmf_pkg::KIND_CONN: begin
        if (!item_i.connect_failed) begin
          conn_d = 1'b1;
        end
      end
      mmf_pkg::KIND_DISC: begin
        conn_d   = 1'b0;
        notify_d = 1'b0;
      end
      mmf_pkg::KIND_NOTIFY: begin
        notify_d = item_i.notify_enable;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/mmf_emit.sv
// Result shift register: holds one burst and hands its entries out one per cycle while the output is ready.
`timescale 1ns / 1ps

module mmf_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  mmf_pkg::burst_t             burst_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output mmf_pkg::res_t               out_res_o,
  output logic                        out_last_o,
  output logic                        can_load_o
);

  mmf_pkg::res_t [mmf_pkg::MAX_RESULTS-1:0] ent_q;
  logic [mmf_pkg::CNT_W-1:0]                left_q;
  logic                                     take;

  assign out_valid_o = (left_q != '0);
  assign out_res_o   = ent_q[0];
  assign out_last_o  = (left_q == mmf_pkg::CNT_W'(1));
  assign take        = out_valid_o && out_ready_i;
  // take a new request when empty or while the final entry of the burst leaves
  assign can_load_o  = !out_valid_o || (take && out_last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (load_i) begin
      left_q <= burst_i.count;
    end else if (take) begin
      left_q <= left_q - mmf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= burst_i.ent;
    end else if (take) begin
      for (int i = 0; i < mmf_pkg::MAX_RESULTS - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

endmodule

FILE: sv/mmf_checker.sv
// Port-level assertions of the fragmenter and the bind that attaches them.
`timescale 1ns / 1ps

module mmf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_frame_end,
  input logic       out_message_end,
  input logic [1:0] out_status,
  input logic       out_run_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
      && $stable(out_frame_end) && $stable(out_message_end)
      && $stable(out_status) && $stable(out_run_last))
    else $error("stalled result changed");

  // no new request while a burst still has entries after the current one
  a_ready_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !out_valid || (out_ready && out_run_last))
    else $error("request taken while burst pending");

  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != mmf_pkg::ST_FRAME |-> out_run_last
      && out_frame_byte == 8'd0 && !out_frame_end && !out_message_end)
    else $error("status result malformed");

  a_msg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_message_end |-> out_frame_end && out_run_last
      && out_status == mmf_pkg::ST_FRAME)
    else $error("message end without frame end");

endmodule

bind mtu_message_fragmenter mmf_checker u_mmf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_frame_byte  (out_o.frame_byte),
  .out_frame_end   (out_o.frame_end),
  .out_message_end (out_o.message_end),
  .out_status      (out_o.status),
  .out_run_last    (out_o.run_last)
);

FILE: bench/tb_mtu_message_fragmenter.sv
// Self-checking testbench of the MTU message fragmenter, with its own frame predictor.
`timescale 1ns / 1ps

module tb_mtu_message_fragmenter;
  import mmf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 8;

  typedef struct {
    logic [7:0] data;
    logic       fend;
    logic       mend;
    status_e    st;
    logic       last;
  } frag_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mmf_in_if  req_if ();
  mmf_out_if frag_if ();
  mmf_cfg_if mtu_if ();

  mtu_message_fragmenter dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (frag_if),
    .cfg_i (mtu_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state
  logic [15:0] mtu_m      = MTU_RESET;
  logic        conn_m     = 1'b0;
  logic        notif_m    = 1'b0;
  logic [7:0]  seq_next_m = 8'd0;
  logic        active_m   = 1'b0;
  logic [15:0] left_m     = 16'd0;
  logic [7:0]  cap_m      = 8'd0;
  logic [7:0]  room_m     = 8'd0;
  logic [7:0]  seq_cur_m  = 8'd0;

  item_t       request_q[$];
  frag_t       frag_expect_q[$];
  item_t       drv_item;
  logic        drv_busy = 1'b0;
  logic        calm     = 1'b0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  function automatic frag_t frag(logic [7:0] b, logic fe, logic me, status_e st);
    frag_t f;
    f.data = b;
    f.fend = fe;
    f.mend = me;
    f.st   = st;
    f.last = 1'b0;
    return f;
  endfunction

  // Set the payload room of a new frame; return the last-frame flag if the rest fits.
  function automatic logic [7:0] start_frame_room(logic [7:0] hdr);
    logic [7:0] fit;
    fit = cap_m - hdr;
    if ({8'd0, fit} >= left_m) begin
      room_m = left_m[7:0];
      return FLAG_LAST;
    end
    room_m = fit;
    return 8'h00;
  endfunction

  function automatic void predict_fragments(item_t it);
    frag_t       run[$];
    logic [15:0] room;
    logic [7:0]  flags;
    case (it.kind)
      KIND_START: begin
        active_m = 1'b0;
        if (!(conn_m && notif_m)) begin
          run.push_back(frag(8'h00, 1'b0, 1'b0, ST_NOT_READY));
        end else begin
          seq_cur_m  = seq_next_m;
          seq_next_m = seq_next_m + 8'd1;
          room = (mtu_m > MTU_OVERHEAD) ? mtu_m - MTU_OVERHEAD : 16'd0;
          if (room <= MIN_ROOM) begin
            run.push_back(frag(8'h00, 1'b0, 1'b0, ST_MTU_SMALL));
          end else if (it.message_length != 16'd0) begin
            if (room > 16'(FRAME_BUFFER_BYTES)) room = 16'(FRAME_BUFFER_BYTES);
            cap_m    = room[7:0];
            left_m   = it.message_length;
            active_m = 1'b1;
            flags = FLAG_FIRST | start_frame_room(FIRST_HDR);
            run.push_back(frag(MSG_TYPE, 1'b0, 1'b0, ST_FRAME));
            run.push_back(frag(flags, 1'b0, 1'b0, ST_FRAME));
            run.push_back(frag(seq_cur_m, 1'b0, 1'b0, ST_FRAME));
            run.push_back(frag(it.message_length[7:0], 1'b0, 1'b0, ST_FRAME));
            run.push_back(frag(it.message_length[15:8], 1'b0, 1'b0, ST_FRAME));
          end
        end
      end
      KIND_BYTE: begin
        if (active_m) begin
          left_m = left_m - 16'd1;
          if (room_m != 8'd0) room_m = room_m - 8'd1;
          if (left_m == 16'd0) begin
            active_m = 1'b0;
            room_m   = 8'd0;
            run.push_back(frag(it.payload_byte, 1'b1, 1'b1, ST_FRAME));
          end else if (room_m == 8'd0) begin
            flags = start_frame_room(NEXT_HDR);
            run.push_back(frag(it.payload_byte, 1'b1, 1'b0, ST_FRAME));
            run.push_back(frag(MSG_TYPE, 1'b0, 1'b0, ST_FRAME));
            run.push_back(frag(flags, 1'b0, 1'b0, ST_FRAME));
            run.push_back(frag(seq_cur_m, 1'b0, 1'b0, ST_FRAME));
          end else begin
            run.push_back(frag(it.payload_byte, 1'b0, 1'b0, ST_FRAME));
          end
        end
      end
      KIND_CONN: begin
        if (!it.connect_failed) conn_m = 1'b1;
      end
      KIND_DISC: begin
        conn_m  = 1'b0;
        notif_m = 1'b0;
      end
      KIND_NOTIFY: notif_m = it.notify_enable;
      default: ;
    endcase
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) frag_expect_q.push_back(run[i]);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Drive requests and output backpressure at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && !drv_busy && request_q.size() > 0 &&
        (calm || $urandom_range(99) >= 16)) begin
      drv_item = request_q.pop_front();
      drv_busy = 1'b1;
    end
    req_if.valid          <= drv_busy;
    req_if.kind           <= drv_item.kind;
    req_if.message_length <= drv_item.message_length;
    req_if.payload_byte   <= drv_item.payload_byte;
    req_if.connect_failed <= drv_item.connect_failed;
    req_if.notify_enable  <= drv_item.notify_enable;
    frag_if.ready         <= calm || ($urandom_range(99) >= 16);
  end

  // Predict on accepted requests, check results, track the MTU register
  always @(posedge clk_i) begin
    frag_t e;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_mtu_message_fragmenter NOT OK");
      $finish;
    end else begin
      if (mtu_if.valid && mtu_if.ready) mtu_m = mtu_if.data;
      if (req_if.valid && req_if.ready) begin
        predict_fragments(drv_item);
        drv_busy = 1'b0;
      end
      if (frag_if.valid && frag_if.ready) begin
        if (frag_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result byte=%02h st=%0d",
                                  frag_if.frame_byte, frag_if.status));
        end else begin
          e = frag_expect_q.pop_front();
          if (frag_if.frame_byte !== e.data || frag_if.frame_end !== e.fend ||
              frag_if.message_end !== e.mend || frag_if.status !== e.st ||
              frag_if.run_last !== e.last)
            note_mismatch($sformatf(
              "got byte=%02h fe=%b me=%b st=%0d rl=%b, want byte=%02h fe=%b me=%b st=%0d rl=%b",
              frag_if.frame_byte, frag_if.frame_end, frag_if.message_end, frag_if.status,
              frag_if.run_last, e.data, e.fend, e.mend, e.st, e.last));
        end
      end
    end
  end

  task automatic queue_item(input logic [2:0] kind, input logic [15:0] len,
                            input logic [7:0] pb, input logic cf, input logic ne);
    item_t it;
    it.kind           = kind;
    it.message_length = len;
    it.payload_byte   = pb;
    it.connect_failed = cf;
    it.notify_enable  = ne;
    request_q.push_back(it);
  endtask

  task automatic queue_link_up();
    queue_item(KIND_CONN, 16'($urandom), 8'($urandom), 1'b0, 1'($urandom));
    queue_item(KIND_NOTIFY, 16'($urandom), 8'($urandom), 1'($urandom), 1'b1);
  endtask

  // Start plus payload; optionally drop a link event somewhere in the payload.
  task automatic queue_message(input int unsigned len, input int unsigned sent,
                               input bit disturb);
    int unsigned at;
    at = $urandom_range(sent);
    queue_item(KIND_START, 16'(len), 8'($urandom), 1'($urandom), 1'($urandom));
    for (int unsigned i = 0; i < sent; i++) begin
      if (disturb && i == at)
        queue_item(3'($urandom_range(KIND_NOTIFY, KIND_CONN)), 16'($urandom),
                   8'($urandom), 1'($urandom), 1'($urandom));
      queue_item(KIND_BYTE, 16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (request_q.size() > 0 || drv_busy || frag_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mtu(input logic [15:0] value);
    @(negedge clk_i);
    mtu_if.valid <= 1'b1;
    mtu_if.data  <= value;
    @(posedge clk_i);
    while (!mtu_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    mtu_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned picked;
    int unsigned len;
    logic [15:0] small_mtu [3];
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.kind           = KIND_START;
    req_if.message_length = 16'd0;
    req_if.payload_byte   = 8'd0;
    req_if.connect_failed = 1'b0;
    req_if.notify_enable  = 1'b0;
    frag_if.ready         = 1'b0;
    mtu_if.valid          = 1'b0;
    mtu_if.data           = 16'd0;
    drv_item              = '0;
    small_mtu[0]          = 16'd0;
    small_mtu[1]          = 16'd3;
    small_mtu[2]          = 16'd8;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Link not ready, stray bytes, failed connect, then a short single-frame message
    queue_item(KIND_START, 16'd5, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_BYTE, 16'd0, 8'h5A, 1'b0, 1'b0);
    queue_item(KIND_CONN, 16'd0, 8'h00, 1'b1, 1'b1);
    queue_item(KIND_START, 16'd0, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_CONN, 16'd0, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_START, 16'd7, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_NOTIFY, 16'd0, 8'h00, 1'b0, 1'b1);
    queue_item(KIND_START, 16'd0, 8'hFF, 1'b1, 1'b1);
    queue_item(KIND_START, 16'd3, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_BYTE, 16'hFFFF, 8'h00, 1'b1, 1'b1);
    queue_item(KIND_BYTE, 16'h0000, 8'hFF, 1'b0, 1'b0);
    queue_item(KIND_BYTE, 16'hFFFF, 8'hA5, 1'b1, 1'b1);
    for (int k = 5; k <= 7; k++) queue_item(3'(k), 16'hFFFF, 8'hFF, 1'b1, 1'b1);
    // Longest message, link events inside it, then abort by a refused start
    queue_item(KIND_START, 16'hFFFF, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_BYTE, 16'd0, 8'h81, 1'b0, 1'b0);
    queue_item(KIND_BYTE, 16'd0, 8'h7E, 1'b0, 1'b0);
    queue_item(KIND_DISC, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
    queue_item(KIND_BYTE, 16'd0, 8'h3C, 1'b0, 1'b0);
    queue_item(KIND_NOTIFY, 16'd0, 8'h00, 1'b0, 1'b0);
    queue_item(KIND_START, 16'd9, 8'h00, 1'b0, 1'b0);
    queue_link_up();
    wait_idle();

    // MTU too small: zero, at the overhead, at the room limit
    foreach (small_mtu[i]) begin
      write_mtu(small_mtu[i]);
      queue_item(KIND_START, 16'd4, 8'h00, 1'b0, 1'b0);
      wait_idle();
    end
    // Smallest usable room, the buffer cap and the largest MTU
    write_mtu(16'd9);
    queue_message(10, 10, 1'b0);
    wait_idle();
    write_mtu(16'd247);
    queue_message(6, 6, 1'b0);
    wait_idle();
    write_mtu(16'hFFFF);
    queue_message(241, 4, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      case ($urandom_range(9))
        0:       write_mtu(16'($urandom_range(8)));
        1:       write_mtu(16'($urandom_range(65535, 248)));
        default: write_mtu(16'($urandom_range(40, 9)));
      endcase
      calm = (ph == 2);
      queue_link_up();
      picked = 0;
      while (picked < 30) begin
        len = $urandom_range(30);
        case ($urandom_range(99)) inside
          [0:64]: begin
            queue_message(len, len, 1'b0);
            picked += len + 1;
          end
          [65:74]: begin
            // link event inside the message; restore the link afterwards
            queue_message(len, len, 1'b1);
            queue_link_up();
            picked += len + 1;
          end
          [75:84]: begin
            // broken message: a new start cuts it short
            queue_message(16'($urandom), $urandom_range(6), 1'b0);
            picked += 2;
          end
          [85:92]: begin
            queue_item(3'($urandom_range(7, 5)), 16'($urandom), 8'($urandom),
                       1'($urandom), 1'($urandom));
            queue_item(KIND_BYTE, 16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
          end
          default: begin
            queue_item(3'($urandom_range(KIND_NOTIFY, KIND_CONN)), 16'($urandom),
                       8'($urandom), 1'($urandom), 1'($urandom));
            queue_item(KIND_START, 16'($urandom_range(4)), 8'($urandom), 1'($urandom),
                       1'($urandom));
            queue_link_up();
            picked += 1;
          end
        endcase
      end
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("tb_mtu_message_fragmenter OK");
    end else begin
      $display("tb_mtu_message_fragmenter NOT OK");
    end
    $finish;
  end

endmodule
